[hdl/fat_volume_geometry_assert.svh]
// Assertion macros shared by the FAT volume geometry RTL.
`ifndef FAT_VOLUME_GEOMETRY_ASSERT_SVH
`define FAT_VOLUME_GEOMETRY_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define FATVG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fat_volume_geometry: check failed");

// Next-cycle implication, disabled while reset is held.
`define FATVG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fat_volume_geometry: check failed");

`endif

[hdl/fatvg_pkg.sv]
// Types and constants shared by the FAT volume geometry pipeline.
package fatvg_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] CFG_FAT12_LIMIT  = 3'd0;
  localparam logic [2:0] CFG_FAT12_MAXCL  = 3'd1;
  localparam logic [2:0] CFG_FAT16_MAXCL  = 3'd2;
  localparam logic [2:0] CFG_FAT12_ROOT   = 3'd3;
  localparam logic [2:0] CFG_FAT16_ROOT   = 3'd4;
  localparam logic [2:0] CFG_COPIES       = 3'd5;

  // Reset values
  localparam logic [21:0] RST_FAT12_LIMIT = 22'd32768;
  localparam logic [11:0] RST_FAT12_MAXCL = 12'd4084;
  localparam logic [15:0] RST_FAT16_MAXCL = 16'd65524;
  localparam logic [15:0] RST_FAT12_ROOT  = 16'd112;
  localparam logic [15:0] RST_FAT16_ROOT  = 16'd512;
  localparam logic [2:0]  RST_COPIES      = 3'd2;

  // Fixed caps and band edges
  localparam logic [15:0] SMALL_MAXCL     = 16'd1021;
  localparam logic [23:0] SMALL_MAXFAT    = 24'd3;
  localparam logic [23:0] FAT12_MAXFAT    = 24'd12;
  localparam logic [23:0] FAT16_MAXFAT    = 24'd256;
  localparam logic [21:0] SMALL_SIZE_KIB  = 22'd16384;

  typedef struct packed {
    logic [21:0] limit;
    logic [11:0] max12;
    logic [15:0] max16;
    logic [15:0] root12;
    logic [15:0] root16;
    logic [2:0]  copies;
  } cfg_t;

  // After classification
  typedef struct packed {
    logic        is16;
    logic        tight;
    logic [2:0]  pw;
    logic [11:0] root;
    logic [31:0] data0;
  } cls_t;

  // After FAT estimate
  typedef struct packed {
    logic        is16;
    logic        tight;
    logic [2:0]  pw;
    logic [11:0] root;
    logic [31:0] data0;
    logic [31:0] fat;
  } est_t;

  // After FATs taken out of the data area
  typedef struct packed {
    logic        is16;
    logic        tight;
    logic [2:0]  pw;
    logic [11:0] root;
    logic [31:0] d1;
    logic [23:0] fat;
  } rem_t;

  // After the cluster cap
  typedef struct packed {
    logic        is16;
    logic [2:0]  pw;
    logic [11:0] root;
    logic [15:0] cc;
    logic [23:0] fat;
    logic [23:0] data;
  } cap_t;

  typedef struct packed {
    logic [23:0] total;
    logic [23:0] data;
    logic [15:0] cc;
    logic [8:0]  fat;
    logic [7:0]  spc;
    logic [11:0] root;
    logic        is16;
  } res_t;

endpackage

[hdl/fatvg_classify.sv]
// Stage one: FAT type, cluster shift band, root size and raw data area.
module fatvg_classify import fatvg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [21:0] in_size,
  output logic        out_valid,
  input  logic        out_ready,
  output cls_t        out_word
);

  logic        valid_r;
  cls_t        word_r;
  cls_t        word_nxt;
  logic [11:0] mib;
  logic [2:0]  pw12;

  assign in_ready = !valid_r || out_ready;
  assign mib      = in_size[21:10];

  always_comb begin
    word_nxt = '0;
    word_nxt.is16  = in_size > cfg.limit;
    word_nxt.tight = in_size <= SMALL_SIZE_KIB;
    if (in_size <= 22'd2048) pw12 = 3'd0;
    else if (in_size <= 22'd4096) pw12 = 3'd1;
    else if (in_size <= 22'd8192) pw12 = 3'd2;
    else if (in_size <= 22'd16384) pw12 = 3'd3;
    else pw12 = 3'd4;
    if (word_nxt.is16) begin
      if (mib <= 12'd128) word_nxt.pw = 3'd2;
      else if (mib <= 12'd256) word_nxt.pw = 3'd3;
      else if (mib <= 12'd512) word_nxt.pw = 3'd4;
      else if (mib <= 12'd1024) word_nxt.pw = 3'd5;
      else if (mib <= 12'd2048) word_nxt.pw = 3'd6;
      else word_nxt.pw = 3'd7;
      word_nxt.root = cfg.root16[15:4];
    end else begin
      // small volumes use four times the cluster size
      word_nxt.pw   = word_nxt.tight ? pw12 + 3'd2 : pw12;
      word_nxt.root = cfg.root12[15:4];
    end
    word_nxt.data0 = {9'd0, in_size, 1'b0} - {20'd0, word_nxt.root} - 32'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word_r <= word_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule

[hdl/fatvg_fat.sv]
// Stages two and three: FAT size estimate, then FAT copies removed from the data area.
module fatvg_fat import fatvg_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic in_valid,
  output logic in_ready,
  input  cls_t in_word,
  output logic out_valid,
  input  logic out_ready,
  output rem_t out_word
);

  logic        est_valid_r;
  est_t        est_r;
  est_t        est_nxt;
  logic        est_ready;
  logic        rem_valid_r;
  rem_t        rem_r;
  rem_t        rem_nxt;
  logic [31:0] cc0;
  logic [31:0] e;
  logic [31:0] b;
  logic [31:0] fat_prod;

  assign est_ready = !rem_valid_r || out_ready;
  assign in_ready  = !est_valid_r || est_ready;

  // FAT estimate from the first cluster count
  always_comb begin
    cc0 = in_word.data0 >> in_word.pw;
    e   = cc0 + 32'd2;
    b   = e + {e[30:0], 1'b0};
    est_nxt.is16  = in_word.is16;
    est_nxt.tight = in_word.tight;
    est_nxt.pw    = in_word.pw;
    est_nxt.root  = in_word.root;
    est_nxt.data0 = in_word.data0;
    if (in_word.is16) begin
      est_nxt.fat = {8'd0, e[31:8]} + {31'd0, |e[7:0]};
    end else begin
      est_nxt.fat = {10'd0, b[31:10]} + {31'd0, |b[9:0]};
    end
  end

  always_comb begin
    fat_prod      = est_r.fat * {29'd0, cfg.copies};
    rem_nxt.is16  = est_r.is16;
    rem_nxt.tight = est_r.tight;
    rem_nxt.pw    = est_r.pw;
    rem_nxt.root  = est_r.root;
    rem_nxt.d1    = est_r.data0 - fat_prod;
    rem_nxt.fat   = est_r.fat[23:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      est_valid_r <= 1'b0;
      rem_valid_r <= 1'b0;
    end else begin
      if (in_ready) est_valid_r <= in_valid;
      if (est_ready) rem_valid_r <= est_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) est_r <= est_nxt;
    if (est_ready && est_valid_r) rem_r <= rem_nxt;
  end

  assign out_valid = rem_valid_r;
  assign out_word  = rem_r;

endmodule

[hdl/fatvg_fit.sv]
// Stages four and five: cluster count, cap, and the totals of the final layout.
module fatvg_fit import fatvg_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic in_valid,
  output logic in_ready,
  input  rem_t in_word,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_word
);

  logic        cap_valid_r;
  cap_t        cap_r;
  cap_t        cap_nxt;
  logic        cap_ready;
  logic        res_valid_r;
  res_t        res_r;
  res_t        res_nxt;
  logic [31:0] cc1;
  logic [15:0] maxc;
  logic [23:0] maxfat;
  logic        over;
  logic [31:0] fat_area;

  assign cap_ready = !res_valid_r || out_ready;
  assign in_ready  = !cap_valid_r || cap_ready;

  always_comb begin
    cc1 = in_word.d1 >> in_word.pw;
    if (in_word.is16) begin
      maxc   = cfg.max16;
      maxfat = FAT16_MAXFAT;
    end else if (in_word.tight) begin
      maxc   = SMALL_MAXCL;
      maxfat = SMALL_MAXFAT;
    end else begin
      maxc   = {4'd0, cfg.max12};
      maxfat = FAT12_MAXFAT;
    end
    over = cc1 > {16'd0, maxc};
    cap_nxt.is16 = in_word.is16;
    cap_nxt.pw   = in_word.pw;
    cap_nxt.root = in_word.root;
    // capped data area reduces to maxc clusters of full size
    if (over) begin
      cap_nxt.cc   = maxc;
      cap_nxt.fat  = maxfat;
      cap_nxt.data = 24'({16'd0, maxc} << in_word.pw);
    end else begin
      cap_nxt.cc   = cc1[15:0];
      cap_nxt.fat  = in_word.fat;
      cap_nxt.data = 24'(cc1 << in_word.pw);
    end
  end

  always_comb begin
    fat_area      = {8'd0, cap_r.fat} * {29'd0, cfg.copies};
    res_nxt.total = cap_r.data + 24'd1 + fat_area[23:0] + {12'd0, cap_r.root};
    res_nxt.data  = cap_r.data;
    res_nxt.cc    = cap_r.cc;
    res_nxt.fat   = cap_r.fat[8:0];
    res_nxt.spc   = 8'(9'd1 << cap_r.pw);
    res_nxt.root  = cap_r.root;
    res_nxt.is16  = cap_r.is16;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      if (in_ready) cap_valid_r <= in_valid;
      if (cap_ready) res_valid_r <= cap_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) cap_r <= cap_nxt;
    if (cap_ready && cap_valid_r) res_r <= res_nxt;
  end

  assign out_valid = res_valid_r;
  assign out_word  = res_r;

endmodule

[hdl/fat_volume_geometry.sv]
// Top level of the FAT12/FAT16 volume geometry calculator.
//
//  channel | direction | handshake            | word
//  in_     | input     | in_valid / in_ready  | in_size_kib
//  out_    | output    | out_valid/ out_ready | total, data, clusters, fat, spc, root, type
//  cfg_    | input     | cfg_valid/ cfg_ready | cfg_index, cfg_data
//
// Five register stages: classify, FAT estimate, FAT removal, cluster cap, totals.
// One word per cycle sustained while out_ready stays high.
// Each stage holds its word while the stage below is full and stalled; a bubble
// anywhere lets in_ready stay high, so a waiting result does not block new input.
// Synchronous active-low reset clears the stage valid bits and loads the register
// defaults; cfg_ready is always high.
`include "fat_volume_geometry_assert.svh"

module fat_volume_geometry import fatvg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [21:0] in_size_kib,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] out_total_sectors,
  output logic [23:0] out_data_sectors,
  output logic [15:0] out_cluster_count,
  output logic [8:0]  out_fat_sectors,
  output logic [7:0]  out_cluster_sectors,
  output logic [11:0] out_root_dir_sectors,
  output logic        out_is_fat16
);

  cfg_t cfg_r;
  logic cls_valid;
  logic cls_ready;
  cls_t cls_word;
  logic rem_valid;
  logic rem_ready;
  rem_t rem_word;
  res_t res_word;

  // Register file; the user must make writes only arrive while the pipeline is empty, the block does not enforce it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.limit  <= RST_FAT12_LIMIT;
      cfg_r.max12  <= RST_FAT12_MAXCL;
      cfg_r.max16  <= RST_FAT16_MAXCL;
      cfg_r.root12 <= RST_FAT12_ROOT;
      cfg_r.root16 <= RST_FAT16_ROOT;
      cfg_r.copies <= RST_COPIES;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FAT12_LIMIT: cfg_r.limit  <= cfg_data[21:0];
        CFG_FAT12_MAXCL: cfg_r.max12  <= cfg_data[11:0];
        CFG_FAT16_MAXCL: cfg_r.max16  <= cfg_data[15:0];
        CFG_FAT12_ROOT:  cfg_r.root12 <= cfg_data[15:0];
        CFG_FAT16_ROOT:  cfg_r.root16 <= cfg_data[15:0];
        CFG_COPIES:      cfg_r.copies <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  fatvg_classify u_classify (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_size   (in_size_kib),
    .out_valid (cls_valid),
    .out_ready (cls_ready),
    .out_word  (cls_word)
  );

  fatvg_fat u_fat (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (cls_valid),
    .in_ready  (cls_ready),
    .in_word   (cls_word),
    .out_valid (rem_valid),
    .out_ready (rem_ready),
    .out_word  (rem_word)
  );

  fatvg_fit u_fit (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (rem_valid),
    .in_ready  (rem_ready),
    .in_word   (rem_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (res_word)
  );

  assign out_total_sectors    = res_word.total;
  assign out_data_sectors     = res_word.data;
  assign out_cluster_count    = res_word.cc;
  assign out_fat_sectors      = res_word.fat;
  assign out_cluster_sectors  = res_word.spc;
  assign out_root_dir_sectors = res_word.root;
  assign out_is_fat16         = res_word.is16;

  // cluster size is always a single power of two
  `FATVG_ASSERT_NOW(a_spc_pow2, clk, rst_n, out_valid, $onehot(out_cluster_sectors))
  // FAT16 never uses fewer than four sectors per cluster
  `FATVG_ASSERT_NOW(a_fat16_spc, clk, rst_n, out_valid && out_is_fat16,
                    out_cluster_sectors >= 8'd4)
  // the cap holds the FAT16 cluster count at or below its register
  `FATVG_ASSERT_NOW(a_fat16_cap, clk, rst_n, out_valid && out_is_fat16,
                    out_cluster_count <= cfg_r.max16)

endmodule

[tb/tb_fat_volume_geometry.sv]
// Self-checking testbench for the FAT12/FAT16 volume geometry pipeline.
`timescale 1ns / 1ps

module tb_fat_volume_geometry;
  import fatvg_pkg::*;

  // Directed rows either load a register or send one size word
  typedef enum logic {ROW_SIZE, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [2:0]  reg_idx;
    logic [31:0] wdata;
    logic [21:0] size;
    logic        typed;   // want holds a hand-worked answer
    res_t        want;
  } stim_row_t;

  localparam int N_DIRECTED = 26;
  localparam int N_PHASES = 8;
  localparam int SIZES_PER_PHASE = 190;

  // Directed stimulus. Hand-worked answers only for the obvious corners at reset
  // settings: empty volume (everything wraps, then the 1021-cluster cap pulls it
  // back), the largest volume (FAT16 cap) and the FAT12 limit itself (FAT12 cap).
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{ROW_SIZE, '0, '0, 22'd0,       1'b1,
      '{24'd4098, 24'd4084, 16'd1021, 9'd3, 8'd4, 12'd7, 1'b0}},
    '{ROW_SIZE, '0, '0, 22'h3FFFFF,  1'b1,
      '{24'd8387617, 24'd8387072, 16'd65524, 9'd256, 8'd128, 12'd32, 1'b1}},
    '{ROW_SIZE, '0, '0, 22'd32768,   1'b1,
      '{24'd65376, 24'd65344, 16'd4084, 9'd12, 8'd16, 12'd7, 1'b0}},
    // tiny volume, then the FAT12 band edges
    '{ROW_SIZE, '0, '0, 22'd1,       1'b0, '0},
    '{ROW_SIZE, '0, '0, 22'd2048,    1'b0, '0},
    '{ROW_SIZE, '0, '0, 22'd2049,    1'b0, '0},
    '{ROW_SIZE, '0, '0, 22'd4096,    1'b0, '0},
    '{ROW_SIZE, '0, '0, 22'd8193,    1'b0, '0},
    '{ROW_SIZE, '0, '0, 22'd16384,   1'b0, '0},
    '{ROW_SIZE, '0, '0, 22'd16385,   1'b0, '0},
    // just over the limit, then the FAT16 MiB band edges
    '{ROW_SIZE, '0, '0, 22'd32769,   1'b0, '0},
    '{ROW_SIZE, '0, '0, 22'd131072,  1'b0, '0},
    '{ROW_SIZE, '0, '0, 22'd132096,  1'b0, '0},
    '{ROW_SIZE, '0, '0, 22'd263168,  1'b0, '0},
    '{ROW_SIZE, '0, '0, 22'd525312,  1'b0, '0},
    '{ROW_SIZE, '0, '0, 22'd1049600, 1'b0, '0},
    '{ROW_SIZE, '0, '0, 22'd2097152, 1'b0, '0},
    '{ROW_SIZE, '0, '0, 22'd2098176, 1'b0, '0},
    // root entries not a multiple of sixteen, copy count beyond four
    '{ROW_REG,  CFG_FAT12_ROOT, 32'd23, '0, 1'b0, '0},
    '{ROW_REG,  CFG_COPIES,     32'd7,  '0, 1'b0, '0},
    '{ROW_SIZE, '0, '0, 22'd3,       1'b0, '0},
    '{ROW_SIZE, '0, '0, 22'd20000,   1'b0, '0},
    // no FAT copies at all; FAT16 root written with junk above its width
    '{ROW_REG,  CFG_COPIES,     32'd0,  '0, 1'b0, '0},
    '{ROW_REG,  CFG_FAT16_ROOT, 32'hFFFFFFFF, '0, 1'b0, '0},
    '{ROW_SIZE, '0, '0, 22'd700000,  1'b0, '0},
    '{ROW_SIZE, '0, '0, 22'd8,       1'b0, '0}
  };

  // Where the cluster size changes
  localparam int unsigned BAND_EDGE [9] = '{
    2048, 4096, 8192, 16384, 132096, 263168, 525312, 1049600, 2098176
  };

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [21:0] in_size_kib;
  logic        out_valid;
  logic        out_ready;
  logic [23:0] out_total_sectors;
  logic [23:0] out_data_sectors;
  logic [15:0] out_cluster_count;
  logic [8:0]  out_fat_sectors;
  logic [7:0]  out_cluster_sectors;
  logic [11:0] out_root_dir_sectors;
  logic        out_is_fat16;

  cfg_t shadow_regs;          // our copy of the register file
  res_t expected_geom [$];    // geometries owed by the pipeline, oldest first
  bit   no_idle;              // set for the stretch where neither side pauses
  int   mismatches;
  int   geoms_checked;
  int   sizes_sent;
  int   settings_used;

  fat_volume_geometry DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_size_kib          (in_size_kib),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_total_sectors    (out_total_sectors),
    .out_data_sectors     (out_data_sectors),
    .out_cluster_count    (out_cluster_count),
    .out_fat_sectors      (out_fat_sectors),
    .out_cluster_sectors  (out_cluster_sectors),
    .out_root_dir_sectors (out_root_dir_sectors),
    .out_is_fat16         (out_is_fat16)
  );

  always #2 clk = ~clk;

  // Geometry for one size under the current registers. Everything is worked in
  // 32 bits and allowed to wrap, exactly as the hardware is meant to, and only
  // trimmed to the port widths at the very end.
  function automatic res_t geometry_of(input logic [21:0] size);
    logic [31:0] sz, mib, root, data, cc, fat, maxc, maxfat, spc, est, diff, total;
    logic [2:0]  pw;
    logic        big;
    res_t        r;
    sz  = {10'd0, size};
    big = sz > {10'd0, shadow_regs.limit};
    if (big) begin
      mib = sz >> 10;
      if (mib <= 32'd128) pw = 3'd2;
      else if (mib <= 32'd256) pw = 3'd3;
      else if (mib <= 32'd512) pw = 3'd4;
      else if (mib <= 32'd1024) pw = 3'd5;
      else if (mib <= 32'd2048) pw = 3'd6;
      else pw = 3'd7;
      maxc   = {16'd0, shadow_regs.max16};
      maxfat = 32'd256;
      root   = {16'd0, shadow_regs.root16} >> 4;
    end else begin
      if (sz <= 32'd2048) pw = 3'd0;
      else if (sz <= 32'd4096) pw = 3'd1;
      else if (sz <= 32'd8192) pw = 3'd2;
      else if (sz <= 32'd16384) pw = 3'd3;
      else pw = 3'd4;
      // up to 16 MiB: clusters four times larger, tight caps
      if (sz <= 32'd16384) begin
        pw     = pw + 3'd2;
        maxc   = 32'd1021;
        maxfat = 32'd3;
      end else begin
        maxc   = {20'd0, shadow_regs.max12};
        maxfat = 32'd12;
      end
      root = {16'd0, shadow_regs.root12} >> 4;
    end
    spc = 32'd1 << pw;

    // first guess at the cluster count sizes the FAT (rounded up)
    data = sz * 32'd2 - root - 32'd1;
    cc   = data >> pw;
    if (big) begin
      est = cc + 32'd2;
      fat = (est >> 8) + ((est[7:0] != 8'd0) ? 32'd1 : 32'd0);
    end else begin
      est = (cc + 32'd2) * 32'd3;
      fat = (est >> 10) + ((est[9:0] != 10'd0) ? 32'd1 : 32'd0);
    end

    // recount once the FAT copies are taken out
    cc   = (data - {29'd0, shadow_regs.copies} * fat) >> pw;
    data = cc * spc;
    if (cc > maxc) begin
      diff = cc - maxc;
      cc   = maxc;
      fat  = maxfat;
      data = data - diff * spc;
    end
    total = data + 32'd1 + fat * {29'd0, shadow_regs.copies} + root;

    r.total = total[23:0];
    r.data  = data[23:0];
    r.cc    = cc[15:0];
    r.fat   = fat[8:0];
    r.spc   = spc[7:0];
    r.root  = root[11:0];
    r.is16  = big;
    return r;
  endfunction

  // Sizes biased towards band edges, the FAT12/FAT16 limit and small volumes;
  // the full-range share makes every input bit toggle.
  function automatic logic [21:0] pick_size();
    int unsigned mode;
    mode = $urandom_range(0, 9);
    case (mode)
      0, 1: return 22'($urandom_range(0, 32'h3FFFFF));
      2: return 22'($urandom_range(0, 64));
      3: return 22'(BAND_EDGE[$urandom_range(0, 8)] + $urandom_range(0, 6) - 3);
      4: return 22'(shadow_regs.limit + $urandom_range(0, 16) - 8);
      5, 6: return 22'($urandom_range(0, shadow_regs.limit));
      default: return 22'($urandom_range(0, 65535));
    endcase
  endfunction

  // Enters and leaves just after a rising edge. Valid is only lowered during a
  // deliberate gap, so back-to-back words keep it high without a glitch.
  task automatic send_size(input logic [21:0] sz, input logic typed, input res_t hand);
    while (!no_idle && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_size_kib <= sz;
    // handshake judged mid-cycle, the word is taken at the next rising edge
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    expected_geom.push_back(typed ? hand : geometry_of(sz));
    sizes_sent++;
    @(posedge clk);
  endtask

  // Sender holds off until the pipeline has handed back everything it owes
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_geom.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    case (idx)
      CFG_FAT12_LIMIT: shadow_regs.limit  = val[21:0];
      CFG_FAT12_MAXCL: shadow_regs.max12  = val[11:0];
      CFG_FAT16_MAXCL: shadow_regs.max16  = val[15:0];
      CFG_FAT12_ROOT:  shadow_regs.root12 = val[15:0];
      CFG_FAT16_ROOT:  shadow_regs.root16 = val[15:0];
      CFG_COPIES:      shadow_regs.copies = val[2:0];
      default: ;
    endcase
    @(posedge clk);
    // one quiet cycle so the next write never lowers and raises valid at once
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Loads a whole register set; half the time the unused upper bits carry junk
  task automatic load_settings(input cfg_t s);
    logic [31:0] junk;
    junk = $urandom_range(0, 1) ? $urandom : 32'd0;
    cfg_write(CFG_FAT12_LIMIT, {junk[31:22], s.limit});
    cfg_write(CFG_FAT12_MAXCL, {junk[31:12], s.max12});
    cfg_write(CFG_FAT16_MAXCL, {junk[31:16], s.max16});
    cfg_write(CFG_FAT12_ROOT,  {junk[31:16], s.root12});
    cfg_write(CFG_FAT16_ROOT,  {junk[31:16], s.root16});
    cfg_write(CFG_COPIES,      {junk[31:3],  s.copies});
    settings_used++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Result side: out_ready drawn afresh every edge, except in the steady stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_idle || ($urandom_range(99) >= 34);
    end
  end

  // Results judged mid-cycle; the word moves at the following rising edge
  always @(negedge clk) begin : result_check
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_geom.size() == 0) begin
        $error("result word with nothing outstanding: total %0d", out_total_sectors);
        mismatches++;
      end else begin
        want = expected_geom.pop_front();
        check_field("total_sectors",    32'(want.total), 32'(out_total_sectors));
        check_field("data_sectors",     32'(want.data),  32'(out_data_sectors));
        check_field("cluster_count",    32'(want.cc),    32'(out_cluster_count));
        check_field("fat_sectors",      32'(want.fat),   32'(out_fat_sectors));
        check_field("cluster_sectors",  32'(want.spc),   32'(out_cluster_sectors));
        check_field("root_dir_sectors", 32'(want.root),  32'(out_root_dir_sectors));
        check_field("is_fat16",         32'(want.is16),  32'(out_is_fat16));
        geoms_checked++;
      end
    end
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2000000;
    $display("Timed out with %0d results outstanding", expected_geom.size());
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    cfg_t s;
    clk         = 1'b0;
    rst_n       = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    in_size_kib = '0;
    out_ready   = 1'b0;
    no_idle     = 1'b0;
    mismatches  = 0;
    geoms_checked = 0;
    sizes_sent  = 0;
    settings_used = 1;
    shadow_regs = '{limit: 22'd32768, max12: 12'd4084, max16: 16'd65524,
                    root12: 16'd112, root16: 16'd512, copies: 3'd2};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table; register rows only once the pipeline has drained
    for (int i = 0; i < N_DIRECTED; i++) begin
      if (DIRECTED[i].kind == ROW_REG) begin
        settle();
        cfg_write(DIRECTED[i].reg_idx, DIRECTED[i].wdata);
      end else begin
        send_size(DIRECTED[i].size, DIRECTED[i].typed, DIRECTED[i].want);
      end
    end

    // Random phases, each under its own register set. The first two are the
    // extremes, the fourth runs with both sides flat out.
    for (int phase = 0; phase < N_PHASES; phase++) begin
      settle();
      case (phase)
        0: s = '{limit: 22'd0, max12: 12'd1, max16: 16'd1,
                 root12: 16'hFFFF, root16: 16'hFFFF, copies: 3'd0};
        1: s = '{limit: 22'h3FFFFF, max12: 12'hFFF, max16: 16'hFFFF,
                 root12: 16'd0, root16: 16'd0, copies: 3'd7};
        2: s = '{limit: 22'd32768, max12: 12'd4084, max16: 16'd65524,
                 root12: 16'd112, root16: 16'd512, copies: 3'd1};
        3: s = '{limit: 22'd16384, max12: 12'd4084, max16: 16'hFFFF,
                 root12: 16'd224, root16: 16'd1024, copies: 3'd4};
        default: begin
          s.limit  = $urandom_range(0, 1) ? 22'($urandom_range(0, 32'h3FFFFF))
                                          : 22'($urandom_range(0, 65536));
          s.max12  = 12'($urandom_range(1, 4095));
          s.max16  = 16'($urandom_range(1, 65535));
          // root entries mostly whole sectors, now and then ragged
          s.root12 = $urandom_range(0, 3) ? 16'($urandom_range(0, 4095) << 4)
                                          : 16'($urandom_range(0, 65535));
          s.root16 = $urandom_range(0, 3) ? 16'($urandom_range(0, 4095) << 4)
                                          : 16'($urandom_range(0, 65535));
          s.copies = 3'($urandom_range(0, 7));
        end
      endcase
      load_settings(s);
      no_idle = (phase == 3);
      for (int i = 0; i < SIZES_PER_PHASE; i++) send_size(pick_size(), 1'b0, '0);
      no_idle = 1'b0;
    end

    // Drain, then give the five-stage pipe time to show any stray word
    settle();
    repeat (12) @(posedge clk);

    $display("%0d sizes across %0d register settings, %0d geometries compared",
             sizes_sent, settings_used, geoms_checked);
    $display("Covered FAT12 and FAT16 bands, caps, wrapped tiny volumes, odd roots");
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[fat_volume_geometry.f]
+incdir+hdl
hdl/fatvg_pkg.sv
hdl/fatvg_classify.sv
hdl/fatvg_fat.sv
hdl/fatvg_fit.sv
hdl/fat_volume_geometry.sv
tb/tb_fat_volume_geometry.sv
